@@ rtl/cpb_pkg.sv @@
`timescale 1ns / 1ps

package cpb_pkg;

	// Palette capacity and the widths that follow from it.
	localparam int PALETTE_SIZE = 256;
	localparam int IDX_W        = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
	localparam int CNT_W        = $clog2(PALETTE_SIZE + 1);

	// Fixed field widths of the pixel and result ports.
	localparam int COLOR_W      = 24;
	localparam int INDEX_OUT_W  = 8;
	localparam int COUNT_OUT_W  = 9;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	// One request as it walks down the row of palette cells.
	typedef struct packed {
		logic   vld;    // a request occupies this slot
		logic   clr;    // frame start: clear each cell as the request passes
		color_t color;  // pixel color being looked up
		logic   hit;    // an entry was found or taken upstream
		logic   put;    // the color was appended to a free entry
		idx_t   idx;    // palette index of the hit
	} item_t;

endpackage

@@ rtl/exact_color_palette_builder.sv @@
`timescale 1ns / 1ps
// Each accepted request passes through PALETTE_SIZE cell registers, one per palette entry,
// and then the result register before its result is presented.
// Throughput: one request per cycle; the whole row holds while a result is stalled.
// Reset clears the palette occupancy, the count and the overflow flag at once;
// the block takes requests from the first cycle after reset.
module exact_color_palette_builder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cpb_pkg::COLOR_W-1:0]       pixel_color,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cpb_pkg::INDEX_OUT_W-1:0]   color_index,
	output logic                              new_color,
	output logic [cpb_pkg::COUNT_OUT_W-1:0]   color_count,
	output logic                              overflow
);
	import cpb_pkg::*;

	logic  adv;
	item_t link [PALETTE_SIZE+1];

	// The row moves whenever the result register is free or being taken.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Incoming request enters the first cell.
	always_comb begin
		link[0]       = '0;
		link[0].vld   = in_valid;
		link[0].clr   = frame_start;
		link[0].color = pixel_color;
	end

	// One cell per palette entry.
	for (genvar g = 0; g < PALETTE_SIZE; g++) begin : g_cell
		cpb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cell_idx (IDX_W'(g)),
			.item_i   (link[g]),
			.item_o   (link[g+1])
		);
	end

	cpb_result u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.item_i      (link[PALETTE_SIZE]),
		.out_valid   (out_valid),
		.color_index (color_index),
		.new_color   (new_color),
		.color_count (color_count),
		.overflow    (overflow)
	);

endmodule

@@ rtl/cpb_cell.sv @@
`timescale 1ns / 1ps

module cpb_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  cpb_pkg::idx_t  cell_idx,
	input  cpb_pkg::item_t item_i,
	output cpb_pkg::item_t item_o
);
	import cpb_pkg::*;

	logic   used_q;
	color_t color_q;
	logic   vld_q;
	item_t  item_q;

	logic   used_eff;
	logic   match;
	logic   take;
	item_t  item_n;

	// Compare the passing request against this entry, or claim the entry when free.
	always_comb begin
		used_eff = item_i.clr ? 1'b0 : used_q;
		match    = used_eff && (color_q == item_i.color);
		take     = !item_i.hit && !used_eff;
		item_n   = item_i;
		if (!item_i.hit && match) begin
			item_n.hit = 1'b1;
			item_n.idx = cell_idx;
		end else if (take) begin
			item_n.hit = 1'b1;
			item_n.put = 1'b1;
			item_n.idx = cell_idx;
		end
	end

	// Occupancy of this entry; a frame start empties it as the request goes by.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			vld_q <= item_i.vld;
			if (item_i.vld) begin
				used_q <= used_eff | take;
			end
		end
	end

	// Entry color and the forwarded request payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= item_n;
			if (item_i.vld && take) begin
				color_q <= item_i.color;
			end
		end
	end

	always_comb begin
		item_o     = item_q;
		item_o.vld = vld_q;
	end

endmodule

@@ rtl/cpb_result.sv @@
`timescale 1ns / 1ps

module cpb_result (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  cpb_pkg::item_t                    item_i,
	output logic                              out_valid,
	output logic [cpb_pkg::INDEX_OUT_W-1:0]   color_index,
	output logic                              new_color,
	output logic [cpb_pkg::COUNT_OUT_W-1:0]   color_count,
	output logic                              overflow
);
	import cpb_pkg::*;

	logic vld_q;
	logic ovf_q;
	cnt_t cnt_q;
	idx_t index_q;
	logic new_q;

	logic ovf_base;
	cnt_t cnt_base;
	logic ovf_n;
	cnt_t cnt_n;
	idx_t index_n;
	logic new_n;

	// Resolve the request that leaves the last cell into a result.
	always_comb begin
		ovf_base = item_i.clr ? 1'b0 : ovf_q;
		cnt_base = item_i.clr ? '0 : cnt_q;
		ovf_n    = ovf_base;
		cnt_n    = cnt_base;
		index_n  = '0;
		new_n    = 1'b0;
		if (!ovf_base) begin
			if (item_i.hit) begin
				index_n = item_i.idx;
				new_n   = item_i.put;
				cnt_n   = cnt_base + cnt_t'(item_i.put);
			end else begin
				ovf_n = 1'b1;
			end
		end
	end

	// Palette count and sticky overflow, kept in request order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
		end else if (adv) begin
			vld_q <= item_i.vld;
			if (item_i.vld) begin
				ovf_q <= ovf_n;
				cnt_q <= cnt_n;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (adv && item_i.vld) begin
			index_q <= index_n;
			new_q   <= new_n;
		end
	end

	assign out_valid   = vld_q;
	assign color_index = INDEX_OUT_W'(index_q);
	assign new_color   = new_q;
	assign color_count = COUNT_OUT_W'(cnt_q);
	assign overflow    = ovf_q;

endmodule
